// File: src/periodic_deadline_scheduler_top_defines.svh
// Assertion macros for the scheduler's checker file, pds_chk.sv.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef PERIODIC_DEADLINE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_DEADLINE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pds check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pds check failed");

`endif

// File: src/pds_pkg.sv
// Shared types and constants of the periodic deadline scheduler.
// No dependencies; the other source files that use it refer to it by scoped names.
`default_nettype none
package pds_pkg;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned CNT_W  = $clog2(TICK_W);
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// Register index of period_ticks (paddr[2] selects the 32-bit word).
	localparam logic REG_PERIOD = 1'b0;

	typedef logic [TICK_W-1:0] tick_t;

	// Sequencer to remainder unit.
	typedef struct packed {
		logic  start;
		tick_t dividend;
		tick_t divisor;
	} rem_ctl_t;

	// Remainder unit back to the sequencer.
	typedef struct packed {
		logic  busy;
		logic  done;
		tick_t rem;
	} rem_sts_t;
endpackage
`default_nettype wire

// File: src/pds_ifs.sv
// Valid/ready stream interfaces of the scheduler: tick samples in, fire beats out.
// Depends on pds_pkg for the tick width.
`default_nettype none
interface pds_tick_if;
	logic               valid;
	logic               ready;
	pds_pkg::tick_t     now_ticks;

	modport source (output valid, output now_ticks, input ready);
	modport sink (input valid, input now_ticks, output ready);
endinterface

interface pds_fire_if;
	logic valid;
	logic ready;
	logic fire;

	modport source (output valid, output fire, input ready);
	modport sink (input valid, input fire, output ready);
endinterface
`default_nettype wire

// File: src/periodic_deadline_scheduler_top.sv
// Periodic deadline scheduler. Each beat on tick_in carries the free-running
// 32-bit tick count; each produces exactly one beat on fire_out telling whether
// an update is due. With period_ticks (APB byte address 0) at zero every beat
// fires and the sample becomes the stored update time. Otherwise the elapsed
// time now - last (mod 2^32) is checked: below one period the stored time stays,
// below two periods the stored time advances by one period, and at two or more
// periods it is realigned to its old phase using now mod period and last mod
// period. On the idle, continuous and one-period paths ST_EVAL sets
// fire_out.valid once the output register is free, and the sequencer then
// returns to ST_IDLE for the next sample. Realignment runs both remainders
// through one shared restoring remainder unit, one bit per cycle: each remainder
// takes a launch, a load, one shift per dividend bit and a done strobe, between
// the decision in ST_EVAL and the fix-up in ST_FIX that sets fire_out.valid.
// A stalled fire_out holds the sequencer in ST_EVAL or ST_FIX. tick_in is ready
// only while the sequencer is idle; a finished fire beat waits in its own output
// register, so the next sample can be taken while it is still pending.
`default_nettype none
module periodic_deadline_scheduler_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [pds_pkg::APB_AW-1:0]        paddr,
	input  wire [pds_pkg::APB_DW-1:0]        pwdata,
	output logic [pds_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	pds_tick_if.sink                         tick_in,
	pds_fire_if.source                       fire_out
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REM_NOW,
		ST_REM_LAST,
		ST_FIX
	} state_t;

	state_t              state_q;
	pds_pkg::tick_t      period_q;
	pds_pkg::tick_t      last_q;
	pds_pkg::tick_t      now_q;
	pds_pkg::tick_t      rem_now_q;
	pds_pkg::tick_t      align_q;
	logic                start_q;
	logic                sel_last_q;
	logic                out_valid_q;
	logic                fire_q;

	pds_pkg::rem_ctl_t   rem_ctl;
	pds_pkg::rem_sts_t   rem_sts;

	pds_pkg::tick_t      elapsed;
	logic                below_one;
	logic                at_two;
	logic                out_free;
	logic                cfg_wr;

	// ---------------------------------------------------------------
	// Configuration port: single word, pready tied high.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == pds_pkg::REG_PERIOD) ? period_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cfg_wr && (paddr[2] == pds_pkg::REG_PERIOD)) begin
			period_q <= pwdata;
		end
	end

	// ---------------------------------------------------------------
	// Decision datapath: elapsed time and the one/two period tests.
	// The two-period compare runs at 33 bits so 2*period cannot wrap.
	// ---------------------------------------------------------------
	assign elapsed   = now_q - last_q;
	assign below_one = elapsed < period_q;
	assign at_two    = {1'b0, elapsed} >= {period_q, 1'b0};

	// Output slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || fire_out.ready;

	assign tick_in.ready  = (state_q == ST_IDLE);
	assign fire_out.valid = out_valid_q;
	assign fire_out.fire  = fire_q;

	// Shared remainder unit: first pass on now, second on last.
	assign rem_ctl.start    = start_q;
	assign rem_ctl.dividend = sel_last_q ? last_q : now_q;
	assign rem_ctl.divisor  = period_q;

	pds_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rem_ctl),
		.sts    (rem_sts)
	);

	// ---------------------------------------------------------------
	// Sequencer with its registered outputs.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			start_q     <= 1'b0;
			sel_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
			fire_q      <= 1'b0;
		end else begin
			// Drop the pending beat once the sink takes it.
			if (out_valid_q && fire_out.ready) begin
				out_valid_q <= 1'b0;
			end
			start_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (tick_in.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (period_q == '0) begin
						// Continuous mode: fire and store the sample.
						if (out_free) begin
							last_q      <= now_q;
							fire_q      <= 1'b1;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else if (below_one) begin
						if (out_free) begin
							fire_q      <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else if (at_two) begin
						// Slipped: launch now mod period.
						start_q    <= 1'b1;
						sel_last_q <= 1'b0;
						state_q    <= ST_REM_NOW;
					end else if (out_free) begin
						last_q      <= last_q + period_q;
						fire_q      <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_REM_NOW: begin
					if (rem_sts.done) begin
						start_q    <= 1'b1;
						sel_last_q <= 1'b1;
						state_q    <= ST_REM_LAST;
					end
				end
				ST_REM_LAST: begin
					if (rem_sts.done) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					// Step back one period if the aligned time lies past now.
					if (out_free) begin
						last_q      <= (align_q > now_q) ? (align_q - period_q) : align_q;
						fire_q      <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: sample capture and realignment terms.
	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			now_q <= tick_in.now_ticks;
		end
		if ((state_q == ST_REM_NOW) && rem_sts.done) begin
			rem_now_q <= rem_sts.rem;
		end
		if ((state_q == ST_REM_LAST) && rem_sts.done) begin
			align_q <= now_q - rem_now_q + rem_sts.rem;
		end
	end
endmodule
`default_nettype wire

// File: src/pds_rem_unit.sv
// Restoring remainder unit: one quotient bit per cycle, TICK_W shifts after the load.
// Depends on pds_pkg; driven by the scheduler sequencer.
`default_nettype none
module pds_rem_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pds_pkg::rem_ctl_t    ctl,
	output pds_pkg::rem_sts_t    sts
);
	localparam int unsigned W = pds_pkg::TICK_W;

	logic                          busy_q;
	logic                          done_q;
	logic [pds_pkg::CNT_W-1:0]     cnt_q;
	logic [W-1:0]                  dvd_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  dsr_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic [W-1:0] rem_next;

	// Shift in the next dividend bit, subtract when it fits.
	always_comb begin
		shifted  = {rem_q, dvd_q[W-1]};
		diff     = shifted - {1'b0, dsr_q};
		rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pds_pkg::CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - pds_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= ctl.dividend;
			dsr_q <= ctl.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.rem  = rem_q;
endmodule
`default_nettype wire

// File: src/pds_chk.sv
// Port-level checker for the periodic deadline scheduler, bound to the top level.
// Depends on periodic_deadline_scheduler_top_defines.svh for the assertion macros.
`default_nettype none
`include "periodic_deadline_scheduler_top_defines.svh"
module pds_chk (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire out_fire
);
	// A stalled fire beat holds its value.
	`PDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fire))
	// The sequencer handles one sample at a time.
	`PDS_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	// A new fire beat only appears after the sequencer was busy.
	`PDS_ASSERT_IMP(a_result_after_work, $rose(out_valid), !$past(in_ready))
endmodule

bind periodic_deadline_scheduler_top pds_chk u_pds_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tick_in.valid),
	.in_ready  (tick_in.ready),
	.out_valid (fire_out.valid),
	.out_ready (fire_out.ready),
	.out_fire  (fire_out.fire)
);
`default_nettype wire

// File: tb/sv/pds_fire_checker.sv
// Scoreboard for the periodic deadline scheduler: tracks period writes and readback on the APB
// port, predicts a fire bit for every tick beat and compares it with the fire beats.
// Depends on pds_pkg and the stream interfaces of pds_ifs.sv.
module pds_fire_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pds_pkg::APB_AW-1:0]  paddr,
	input  logic [pds_pkg::APB_DW-1:0]  pwdata,
	input  logic [pds_pkg::APB_DW-1:0]  prdata,
	input  logic                        pready,
	pds_tick_if                         tick,
	pds_fire_if                         fire,
	output int                          outstanding,
	output int                          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	pds_pkg::tick_t sched_period;
	pds_pkg::tick_t sched_last;
	logic           fire_due_q[$];
	int             fails;

	// Advance the stored update time for one tick sample and return the fire bit.
	function automatic logic predict_fire(input pds_pkg::tick_t now_t);
		pds_pkg::tick_t elapsed;
		pds_pkg::tick_t aligned;
		if (sched_period == '0) begin
			sched_last = now_t;
			return 1'b1;
		end
		elapsed = now_t - sched_last;
		if (elapsed < sched_period)
			return 1'b0;
		// compare against two periods at 33 bits so the doubling cannot wrap
		if ({1'b0, elapsed} >= {sched_period, 1'b0}) begin
			aligned = now_t - (now_t % sched_period) + (sched_last % sched_period);
			if (aligned > now_t)
				aligned = aligned - sched_period;
			sched_last = aligned;
		end else begin
			sched_last = sched_last + sched_period;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic due;
		if (!arst_n) begin
			sched_period = '0;
			sched_last = '0;
			fire_due_q.delete();
			fails = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pready && paddr[2] == pds_pkg::REG_PERIOD) begin
				if (pwrite) begin
					sched_period = pwdata;
				end else if (prdata !== sched_period) begin
					$display("%0t: period readback expected %h, got %h",
						$time, sched_period, prdata);
					fails++;
				end
			end
			// retire the fire beat first: it always belongs to an older tick beat
			if (fire.valid && fire.ready) begin
				if (fire_due_q.size() == 0) begin
					$display("%0t: fire beat expected none, got %b", $time, fire.fire);
					fails++;
				end else begin
					due = fire_due_q.pop_front();
					if (fire.fire !== due) begin
						$display("%0t: fire expected %b, got %b", $time, due, fire.fire);
						fails++;
					end
				end
			end
			if (tick.valid && tick.ready)
				fire_due_q.push_back(predict_fire(tick.now_ticks));
			outstanding <= fire_due_q.size();
			fail_count <= fails;
		end
	end
endmodule

// File: tb/sv/tb_periodic_deadline_scheduler_top.sv
// Testbench top for periodic_deadline_scheduler_top: clock, reset, APB period writes,
// tick stimulus with random gaps and fire-side stalls, and the final verdict.
// Depends on pds_pkg, pds_ifs.sv, the scheduler RTL and pds_fire_checker.
module tb_periodic_deadline_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned N_PHASES    = 12;
	localparam int unsigned PHASE_BEATS = 86;
	// Byte address of period_ticks, and one past the end of the register list.
	localparam logic [pds_pkg::APB_AW-1:0] ADDR_PERIOD = {pds_pkg::REG_PERIOD, 2'b00};
	localparam logic [pds_pkg::APB_AW-1:0] ADDR_UNUSED = {~pds_pkg::REG_PERIOD, 2'b00};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [pds_pkg::APB_AW-1:0] paddr;
	logic [pds_pkg::APB_DW-1:0] pwdata;
	logic [pds_pkg::APB_DW-1:0] prdata;
	logic                       pready;
	logic                       quiet;
	int unsigned                cycles = 0;
	int                         outstanding;
	int                         fail_count;
	int                         stall_left = 0;
	pds_pkg::tick_t             phase_period [N_PHASES];

	pds_tick_if tick_ch ();
	pds_fire_if fire_ch ();

	periodic_deadline_scheduler_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tick_in  (tick_ch),
		.fire_out (fire_ch)
	);

	pds_fire_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.tick        (tick_ch),
		.fire        (fire_ch),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #4 clk = ~clk;

	// Guard against a hung block: a lost fire beat or a stuck ready ends up here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Fire-side backpressure: hold ready low for a random stretch, never in quiet phases.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			fire_ch.ready <= 1'b0;
		end else begin
			fire_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 20)
				stall_left = gap_len();
		end
	end

	// Pick the next tick sample. Most steps look like a real free-running counter seen
	// at a rate near the period: under one period, between one and two, or several
	// periods late. The rest repeat or step back a little, or jump anywhere.
	function automatic pds_pkg::tick_t next_now(input pds_pkg::tick_t cur,
			input pds_pkg::tick_t period);
		pds_pkg::tick_t span;
		int unsigned    pick;
		span = (period == '0) ? 32'd1000 : period;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return cur + $urandom_range(0, span - 1);
		if (pick < 75)
			return cur + span + $urandom_range(0, span - 1);
		if (pick < 88)
			return cur + span * $urandom_range(2, 9) + $urandom_range(0, span - 1);
		if (pick < 94)
			return cur - $urandom_range(0, 16);
		return $urandom;
	endfunction

	// Offer one tick beat and hold it until accepted; then maybe drop valid for a while.
	task automatic send_tick(input pds_pkg::tick_t now_t);
		int gap;
		tick_ch.valid <= 1'b1;
		tick_ch.now_ticks <= now_t;
		do @(posedge clk); while (!tick_ch.ready);
		if (!quiet && $urandom_range(0, 99) < 30) begin
			gap = gap_len();
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted fire beat has been seen.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then psel drops before the task returns so transfers never abut.
	task automatic apb_write(input logic [pds_pkg::APB_AW-1:0] addr,
			input logic [pds_pkg::APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// The checker compares prdata in the access cycle.
	task automatic apb_read(input logic [pds_pkg::APB_AW-1:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram the period only once the block has drained, then read it back.
	task automatic set_period(input pds_pkg::tick_t period);
		settle();
		apb_write(ADDR_PERIOD, period);
		apb_read(ADDR_PERIOD);
	endtask

	task automatic run_phase(input pds_pkg::tick_t period, input int unsigned beats);
		pds_pkg::tick_t now_t;
		int unsigned    hold_at;
		set_period(period);
		now_t = $urandom;
		hold_at = $urandom_range(5, beats - 5);
		for (int unsigned i = 0; i < beats; i++) begin
			// hold the sender once per phase until the pipeline is empty
			if (i == hold_at)
				settle();
			now_t = next_now(now_t, period);
			send_tick(now_t);
		end
	endtask

	initial begin
		// Drive every block input to a known value before the first edge.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.now_ticks = '0;
		fire_ch.ready = 1'b0;
		quiet = 1'b0;

		phase_period[0]  = 32'd0;
		phase_period[1]  = 32'd1;
		phase_period[2]  = 32'd2;
		phase_period[3]  = $urandom_range(3, 64);
		phase_period[4]  = $urandom_range(65, 5000);
		phase_period[5]  = 32'h7FFF_FFFF;
		phase_period[6]  = $urandom;
		phase_period[7]  = 32'h8000_0000;
		phase_period[8]  = 32'hFFFF_FFFF;
		phase_period[9]  = $urandom_range(3, 20);
		phase_period[10] = $urandom_range(100, 100000);
		phase_period[11] = 32'd7;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Continuous mode out of reset, at both ends of the tick range.
		send_tick(32'd0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h5555_AAAA);
		send_tick(32'd9);

		// Period 10 from a stored time of 9: idle, one-period advance, advance just
		// under two periods, realign at exactly two periods, realign where the phase
		// lands past now and steps back, then a stored time ahead of now after wrap.
		set_period(32'd10);
		send_tick(32'd12);
		send_tick(32'd19);
		send_tick(32'd38);
		send_tick(32'd49);
		send_tick(32'd120);
		send_tick(32'd5);
		send_tick(32'hFFFF_FFFE);

		// Largest period: twice the period overflows 32 bits, so no realignment.
		set_period(32'hFFFF_FFFF);
		send_tick(32'd0);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'hFFFF_FFFF);

		// Pin the stored time to zero, then realign with two periods just below 2^32.
		set_period(32'd0);
		send_tick(32'd0);
		set_period(32'h7FFF_FFFF);
		send_tick(32'hFFFF_FFFE);
		send_tick(32'h8000_0000);

		// Two periods equal 2^32 exactly: the realign test can never pass.
		set_period(32'h8000_0000);
		send_tick(32'd0);
		send_tick(32'hFFFF_FFFF);

		// Smallest nonzero period, including a repeated sample.
		set_period(32'd1);
		send_tick(32'd3);
		send_tick(32'd4);
		send_tick(32'd4);

		// A write past the register list must leave the period alone.
		settle();
		apb_write(ADDR_UNUSED, '1);
		apb_read(ADDR_PERIOD);

		// Random phases; every third one runs without gaps or stalls.
		for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
			quiet = (ph % 3 == 1);
			run_phase(phase_period[ph], PHASE_BEATS);
		end

		quiet = 1'b0;
		settle();
		// allow for a stray beat after the last one, beyond the longest realign
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/pds_pkg.sv
src/pds_ifs.sv
src/pds_rem_unit.sv
src/periodic_deadline_scheduler_top.sv
src/pds_chk.sv
tb/sv/pds_fire_checker.sv
tb/sv/tb_periodic_deadline_scheduler_top.sv
